@@ hdl/xnb_pkg.sv @@
// xnb_pkg: shared constants, sequencer state type and helper functions
// for the two-input sigmoid network trainer
// no dependencies
package xnb_pkg;

	localparam int unsigned SIG_ENTRIES_DEF = 256;
	localparam int unsigned NUM_WEIGHTS     = 7;
	localparam int unsigned WIDX_W          = 3;
	localparam int unsigned MUL_W           = 32;
	localparam int unsigned LR_W            = 23;

	// weight store slots
	localparam logic [WIDX_W-1:0] W_XK = 3'd0;
	localparam logic [WIDX_W-1:0] W_YK = 3'd1;
	localparam logic [WIDX_W-1:0] W_BK = 3'd2;
	localparam logic [WIDX_W-1:0] W_XZ = 3'd3;
	localparam logic [WIDX_W-1:0] W_YZ = 3'd4;
	localparam logic [WIDX_W-1:0] W_BZ = 3'd5;
	localparam logic [WIDX_W-1:0] W_KZ = 3'd6;

	localparam logic [31:0]     W_RESET  = 32'd32768;
	localparam logic [LR_W-1:0] LR_RESET = 23'd65536;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_H0, ST_H1, ST_H2, ST_H3,
		ST_O0, ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6,
		ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7,
		ST_U8, ST_U9, ST_U10, ST_U11, ST_U12, ST_U13, ST_U14, ST_U15,
		ST_U16, ST_U17, ST_U18, ST_U19, ST_U20, ST_U21, ST_U22, ST_U23,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [31:0] w;
		logic        clip;
	} sat_t;

	// weight plus delta, clipped to the signed 32-bit range
	function automatic sat_t sat_add(input logic [31:0] w, input logic [47:0] d);
		logic signed [47:0] s;
		sat_t r;
		s = $signed({{16{w[31]}}, w}) + $signed(d);
		if (s > 48'sd2147483647) begin
			r.w    = 32'h7FFF_FFFF;
			r.clip = 1'b1;
		end else if (s < -48'sd2147483648) begin
			r.w    = 32'h8000_0000;
			r.clip = 1'b1;
		end else begin
			r.w    = s[31:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

	// shift-subtract division, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid sample at the centre of one table cell over [-8,8), Q0.16
	function automatic logic [15:0] sig_entry(input logic [31:0] idx,
			input logic [31:0] entries);
		logic [63:0] mpos;
		logic [63:0] a;
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] sp;
		logic [63:0] s;
		logic signed [63:0] sum;
		mpos = udiv64((({32'b0, idx} << 1) + 64'd1) << 19, {32'b0, entries});
		a    = (mpos >= 64'd524288) ? (mpos - 64'd524288) : (64'd524288 - mpos);
		r    = a << 6;
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		for (int k = 1; k <= 10; k++) begin
			term = udiv64((term * r) >> 30, 64'(k));
			if ((k & 1) != 0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 64'sd0) begin
			sum = 64'sd0;
		end
		e = sum;
		for (int j = 0; j < 8; j++) begin
			e = (e * e) >> 30;
		end
		sp = (udiv64(64'd1 << 47, (64'd1 << 30) + e) + 64'd1) >> 1;
		s  = (mpos >= 64'd524288) ? sp : (64'd65536 - sp);
		if (s > 64'd65535) begin
			s = 64'd65535;
		end
		return s[15:0];
	endfunction

endpackage

@@ hdl/xnb_mul.sv @@
// xnb_mul: shared signed 32x32 multiplier with registered product
// depends on xnb_pkg
module xnb_mul
	import xnb_pkg::*;
(
	input  logic                       clk,
	input  logic signed [MUL_W-1:0]    op_a,
	input  logic signed [MUL_W-1:0]    op_b,
	output logic signed [2*MUL_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

@@ hdl/xnb_sig_rom.sv @@
// xnb_sig_rom: sigmoid lookup table with registered read
// entries built at elaboration from xnb_pkg::sig_entry
module xnb_sig_rom
	import xnb_pkg::*;
#(
	parameter int unsigned ENTRIES = SIG_ENTRIES_DEF,
	localparam int unsigned IW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic [IW-1:0] addr,
	output logic [15:0]   data_q
);

	logic [15:0] rom [ENTRIES];

	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_rom
		localparam logic [15:0] ENTRY = sig_entry(32'(gi), 32'(ENTRIES));
		assign rom[gi] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

endmodule

@@ hdl/xor_net_backprop_trainer.sv @@
// xor_net_backprop_trainer: two-input network, one hidden sigmoid unit, one output unit
// each item runs the hidden-sum and output-sum states, plus the update states for an
// update; a new item is taken once the result is registered, paced by the single shared
// 32x32 multiplier stepped by the sequencer and the registered sigmoid table read
// reset (arst_n low, asynchronous): all seven weights to one half, learning rate to 1.0
// depends on xnb_pkg, xnb_mul, xnb_sig_rom
module xor_net_backprop_trainer
	import xnb_pkg::*;
#(
	parameter int unsigned SIGMOID_ENTRIES = SIG_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [LR_W-1:0]    cfg_wdata,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [15:0] input_x,
	input  logic signed [15:0] input_y,
	input  logic [12:0]        target_value,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        output_activation,
	output logic [15:0]        hidden_activation,
	output logic               weight_saturated
);

	localparam int unsigned  IW    = $clog2(SIGMOID_ENTRIES);
	localparam logic [IW-1:0] E_MAX = IW'(SIGMOID_ENTRIES - 1);

	state_t state_q, state_d;

	// weight store and learning rate
	logic [31:0]     w_q [NUM_WEIGHTS];
	logic [LR_W-1:0] lr_q;

	// latched item
	logic        upd_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [12:0] t_q;

	// working registers
	logic signed [63:0] acc_q;
	logic [15:0] k_q;
	logic [15:0] z_q;
	logic [31:0] ez_q;   // output error, Q32 scale
	logic [39:0] sz_q;   // scaled output error
	logic [38:0] ek_q;   // hidden error
	logic [46:0] sk_q;   // scaled hidden error
	logic        rng_lo_q;
	logic        rng_hi_q;
	logic        clip_q;

	// result register
	logic        out_valid_q;
	logic [15:0] out_z_q;
	logic [15:0] out_k_q;
	logic        out_sat_q;

	// shared units
	logic [MUL_W-1:0]          mul_a;
	logic [MUL_W-1:0]          mul_b;
	logic signed [2*MUL_W-1:0] mul_q;
	logic [IW-1:0]             rom_addr;
	logic [15:0]               rom_data;

	// weight update path, one weight at a time through a single saturating adder
	logic              w_en;
	logic [WIDX_W-1:0] w_sel;
	logic [47:0]       w_delta;
	logic [31:0]       w_cur;
	sat_t              sat_res;

	logic in_fire;
	logic fin_fire;

	// sums in [-8,8) when the bits above the table span all match the sign
	logic        h_inr;
	logic        o_inr;
	logic [19:0] h_t20;
	logic [19:0] o_t20;

	// derived operands
	logic [31:0] x_ext;
	logic [31:0] y_ext;
	logic [31:0] k_ext;
	logic [16:0] omz;
	logic [16:0] omk;
	logic [17:0] tz_diff;
	logic [31:0] sz_lo;
	logic [31:0] sz_hi;
	logic [31:0] ek_lo;
	logic [31:0] ek_hi;
	logic [31:0] sk_lo;
	logic [31:0] sk_hi;
	logic [31:0] lr_ext;

	assign in_fire  = in_valid && in_ready;
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign h_inr = (&acc_q[63:31]) || !(|acc_q[63:31]);
	assign o_inr = (&acc_q[63:35]) || !(|acc_q[63:35]);
	// offset by +8: flipping the sign bit adds half the span
	assign h_t20 = {~acc_q[31], acc_q[30:12]};
	assign o_t20 = {~acc_q[35], acc_q[34:16]};

	assign x_ext   = {{16{x_q[15]}}, x_q};
	assign y_ext   = {{16{y_q[15]}}, y_q};
	assign k_ext   = {16'b0, k_q};
	assign lr_ext  = {{(32 - LR_W){1'b0}}, lr_q};
	assign omz     = 17'h10000 - {1'b0, z_q};
	assign omk     = 17'h10000 - {1'b0, k_q};
	assign tz_diff = {1'b0, t_q, 4'b0} - {2'b0, z_q};
	// wide errors go through the multiplier as an unsigned low and a signed high part
	assign sz_lo   = {9'b0, sz_q[22:0]};
	assign sz_hi   = {{15{sz_q[39]}}, sz_q[39:23]};
	assign ek_lo   = {9'b0, ek_q[22:0]};
	assign ek_hi   = {{16{ek_q[38]}}, ek_q[38:23]};
	assign sk_lo   = {9'b0, sk_q[22:0]};
	assign sk_hi   = {{8{sk_q[46]}}, sk_q[46:23]};

	// table index: clamp at the ends, otherwise floor((s+8)*E/16)
	assign rom_addr = rng_lo_q ? '0 :
	                  rng_hi_q ? E_MAX : mul_q[20+IW-1:20];

	xnb_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (mul_q)
	);

	xnb_sig_rom #(
		.ENTRIES (SIGMOID_ENTRIES)
	) u_sig_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_data)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_H0;
				end
			end
			ST_O6: begin
				// inference only goes straight to the result
				state_d = upd_q ? ST_U0 : ST_FIN;
			end
			ST_U23: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = state_t'(state_q + 6'd1);
			end
		endcase
	end

	// multiplier operand selection for each sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_H0:  begin mul_a = x_ext;               mul_b = w_q[W_XK]; end
			ST_H1:  begin mul_a = y_ext;               mul_b = w_q[W_YK]; end
			ST_H3:  begin mul_a = {12'b0, h_t20};      mul_b = 32'(SIGMOID_ENTRIES); end
			ST_O0:  begin mul_a = x_ext;               mul_b = w_q[W_XZ]; end
			ST_O1:  begin mul_a = y_ext;               mul_b = w_q[W_YZ]; end
			ST_O2:  begin mul_a = k_ext;               mul_b = w_q[W_KZ]; end
			ST_O4:  begin mul_a = {12'b0, o_t20};      mul_b = 32'(SIGMOID_ENTRIES); end
			// z*(1-z)
			ST_U0:  begin mul_a = {16'b0, z_q};        mul_b = {15'b0, omz}; end
			// (target - z) * z*(1-z)
			ST_U1:  begin
				mul_a = {{14{tz_diff[17]}}, tz_diff};
				mul_b = mul_q[31:0];
			end
			ST_U2:  begin mul_a = lr_ext;              mul_b = mul_q[47:16]; end
			ST_U4:  begin mul_a = x_ext;               mul_b = sz_lo; end
			ST_U5:  begin mul_a = x_ext;               mul_b = sz_hi; end
			ST_U6:  begin mul_a = y_ext;               mul_b = sz_lo; end
			ST_U7:  begin mul_a = y_ext;               mul_b = sz_hi; end
			ST_U8:  begin mul_a = k_ext;               mul_b = sz_lo; end
			ST_U9:  begin mul_a = k_ext;               mul_b = sz_hi; end
			// k*(1-k)
			ST_U10: begin mul_a = k_ext;               mul_b = {15'b0, omk}; end
			ST_U11: begin mul_a = mul_q[31:0];         mul_b = ez_q; end
			// hidden error uses the freshly updated hidden-to-output weight
			ST_U12: begin mul_a = mul_q[63:32];        mul_b = w_q[W_KZ]; end
			ST_U14: begin mul_a = lr_ext;              mul_b = ek_lo; end
			ST_U15: begin mul_a = lr_ext;              mul_b = ek_hi; end
			ST_U18: begin mul_a = x_ext;               mul_b = sk_lo; end
			ST_U19: begin mul_a = x_ext;               mul_b = sk_hi; end
			ST_U20: begin mul_a = y_ext;               mul_b = sk_lo; end
			ST_U21: begin mul_a = y_ext;               mul_b = sk_hi; end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// weight update selection, each delta already floored by the shift
	always_comb begin
		w_en    = 1'b0;
		w_sel   = W_XK;
		w_delta = '0;
		unique case (state_q)
			ST_U4: begin
				w_en    = 1'b1;
				w_sel   = W_BZ;
				w_delta = {{24{sz_q[39]}}, sz_q[39:16]};
			end
			ST_U7: begin
				w_en    = 1'b1;
				w_sel   = W_XZ;
				w_delta = {{12{acc_q[63]}}, acc_q[63:28]};
			end
			ST_U9: begin
				w_en    = 1'b1;
				w_sel   = W_YZ;
				w_delta = {{12{acc_q[63]}}, acc_q[63:28]};
			end
			ST_U11: begin
				w_en    = 1'b1;
				w_sel   = W_KZ;
				w_delta = {{16{acc_q[63]}}, acc_q[63:32]};
			end
			ST_U18: begin
				w_en    = 1'b1;
				w_sel   = W_BK;
				w_delta = {{9{sk_q[46]}}, sk_q[46:8]};
			end
			ST_U21: begin
				w_en    = 1'b1;
				w_sel   = W_XK;
				w_delta = {{4{acc_q[63]}}, acc_q[63:20]};
			end
			ST_U23: begin
				w_en    = 1'b1;
				w_sel   = W_YK;
				w_delta = {{4{acc_q[63]}}, acc_q[63:20]};
			end
			default: begin
				w_en    = 1'b0;
				w_sel   = W_XK;
				w_delta = '0;
			end
		endcase
	end

	always_comb begin
		unique case (w_sel)
			W_XK:    w_cur = w_q[W_XK];
			W_YK:    w_cur = w_q[W_YK];
			W_BK:    w_cur = w_q[W_BK];
			W_XZ:    w_cur = w_q[W_XZ];
			W_YZ:    w_cur = w_q[W_YZ];
			W_BZ:    w_cur = w_q[W_BZ];
			W_KZ:    w_cur = w_q[W_KZ];
			default: w_cur = w_q[W_XK];
		endcase
	end

	assign sat_res = sat_add(w_cur, w_delta);

	// weights, learning rate and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				w_q[i] <= W_RESET;
			end
			lr_q        <= LR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lr_q <= cfg_wdata;
			end
			if (w_en) begin
				w_q[w_sel] <= sat_res.w;
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, stepped by the sequencer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			upd_q  <= req_type;
			x_q    <= input_x;
			y_q    <= input_y;
			t_q    <= target_value;
			clip_q <= 1'b0;
		end
		if (w_en && sat_res.clip) begin
			clip_q <= 1'b1;
		end
		if (fin_fire) begin
			out_z_q   <= z_q;
			out_k_q   <= k_q;
			out_sat_q <= clip_q;
		end
		unique case (state_q)
			// hidden sum: bias term first, then the two products
			ST_H0: acc_q <= {{20{w_q[W_BK][31]}}, w_q[W_BK], 12'b0};
			ST_H1, ST_H2, ST_O3: acc_q <= acc_q + mul_q;
			ST_H3: begin
				rng_lo_q <= !h_inr && acc_q[63];
				rng_hi_q <= !h_inr && !acc_q[63];
			end
			// output sum: input products carry a factor of 16 to reach Q32.32
			ST_O0: acc_q <= {{16{w_q[W_BZ][31]}}, w_q[W_BZ], 16'b0};
			ST_O1: begin
				k_q   <= rom_data;
				acc_q <= acc_q + (mul_q <<< 4);
			end
			ST_O2: acc_q <= acc_q + (mul_q <<< 4);
			ST_O4: begin
				rng_lo_q <= !o_inr && acc_q[63];
				rng_hi_q <= !o_inr && !acc_q[63];
			end
			ST_O6:  z_q  <= rom_data;
			ST_U2:  ez_q <= mul_q[47:16];
			ST_U3:  sz_q <= mul_q[55:16];
			// split products: low part loads, high part adds in shifted by 23
			ST_U5, ST_U7, ST_U9, ST_U15, ST_U19, ST_U21: acc_q <= mul_q;
			ST_U6, ST_U8, ST_U10, ST_U16, ST_U20, ST_U22: acc_q <= acc_q + (mul_q <<< 23);
			ST_U13: ek_q <= mul_q[62:24];
			ST_U17: sk_q <= acc_q[62:16];
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign output_activation = out_z_q;
	assign hidden_activation = out_k_q;
	assign weight_saturated  = out_sat_q;

endmodule
